[hw/rtl/b64d_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// b64d_pkg
// Shared types, constants and helper functions for the base64 stream decoder.
// ============================================================================

package b64d_pkg;

    // Depth of the job queue between the front and the back part.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Character codes with a meaning of their own.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PAD   = 8'h3D;

    // Number of result bytes a job can carry.
    localparam logic [1:0] NUM_ONE   = 2'd1;
    localparam logic [1:0] NUM_TWO   = 2'd2;
    localparam logic [1:0] NUM_THREE = 2'd3;

    // One unit of work for the back part: up to three results.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] num;      // number of results, one to three
        logic       vld;      // zero only for the empty end marker
        logic       str_end;  // the last result closes the string
    } t_job;

    // Maps a character to its 6-bit value; bit 6 flags a non-alphabet
    // character (the pad character included).
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c >= "A" && c <= "Z") begin
            r = {1'b0, 6'(c - 8'h41)};
        end else if (c >= "a" && c <= "z") begin
            r = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= "0" && c <= "9") begin
            r = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end else if (c == CH_PLUS) begin
            r = 7'd62;
        end else if (c == CH_SLASH) begin
            r = 7'd63;
        end
        return r;
    endfunction

    function automatic logic [7:0] byte0(input logic [5:0] s0, input logic [5:0] s1);
        return {s0, s1[5:4]};
    endfunction

    function automatic logic [7:0] byte1(input logic [5:0] s1, input logic [5:0] s2);
        return {s1[3:0], s2[5:2]};
    endfunction

    function automatic logic [7:0] byte2(input logic [5:0] s2, input logic [5:0] s3);
        return {s2[1:0], s3};
    endfunction

endpackage

[hw/rtl/b64d_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// b64d_front
// Classifies each accepted character, keeps the open sextet group and the
// stop flag, and forms one job whenever a character yields results or closes the string.
// ============================================================================

module b64d_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_char_code,
    input  logic               i_final_char,
    output logic               o_job_valid,
    output b64d_pkg::t_job     o_job
);

    logic [5:0] r_s0, r_s1, r_s2;
    logic [1:0] r_cnt;
    logic       r_stopped;
    logic [5:0] n_s0, n_s1, n_s2;
    logic [1:0] n_cnt;
    logic       n_stopped;
    logic [6:0] w_sx;
    logic       w_cmp;

    assign w_sx = b64d_pkg::sextet_of(i_char_code);

    // Decode the character, then close the string on the final one.
    always_comb begin
        n_s0        = r_s0;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_cnt       = r_cnt;
        n_stopped   = r_stopped;
        w_cmp       = 1'b0;
        o_job       = '0;
        if (!r_stopped) begin
            if (w_sx[6]) begin
                n_stopped = 1'b1;
            end else if (r_cnt == 2'd3) begin
                w_cmp         = 1'b1;
                n_cnt         = 2'd0;
                o_job.b0      = b64d_pkg::byte0(r_s0, r_s1);
                o_job.b1      = b64d_pkg::byte1(r_s1, r_s2);
                o_job.b2      = b64d_pkg::byte2(r_s2, w_sx[5:0]);
                o_job.num     = b64d_pkg::NUM_THREE;
                o_job.vld     = 1'b1;
                o_job.str_end = i_final_char;
            end else begin
                case (r_cnt)
                    2'd0:    n_s0 = w_sx[5:0];
                    2'd1:    n_s1 = w_sx[5:0];
                    default: n_s2 = w_sx[5:0];
                endcase
                n_cnt = r_cnt + 2'd1;
            end
        end
        // Flush a partial group, or give the empty end marker.
        if (i_final_char && !w_cmp) begin
            o_job.str_end = 1'b1;
            o_job.b0      = b64d_pkg::byte0(n_s0, n_s1);
            o_job.b1      = b64d_pkg::byte1(n_s1, n_s2);
            o_job.vld     = 1'b1;
            case (n_cnt)
                2'd3:    o_job.num = b64d_pkg::NUM_TWO;
                2'd2:    o_job.num = b64d_pkg::NUM_ONE;
                default: begin
                    o_job.num = b64d_pkg::NUM_ONE;
                    o_job.vld = 1'b0;
                    o_job.b0  = 8'h00;
                end
            endcase
        end
        if (i_final_char) begin
            n_cnt     = 2'd0;
            n_stopped = 1'b0;
        end
    end

    assign o_job_valid = i_accept && (w_cmp || i_final_char);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= 2'd0;
            r_stopped <= 1'b0;
        end else if (i_accept) begin
            r_cnt     <= n_cnt;
            r_stopped <= n_stopped;
        end
    end

    // Sextets of the open group.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

`ifndef SYNTH
    // The empty end marker is a single result that closes the string.
    a_marker_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_valid && !o_job.vld) |-> (o_job.num == b64d_pkg::NUM_ONE && o_job.str_end))
        else $error("end marker with wrong shape");
`endif

endmodule

[hw/rtl/b64d_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// b64d_queue
// Short job queue that lets the front and the back part stall on their own.
// ============================================================================

module b64d_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  b64d_pkg::t_job     i_wr_job,
    input  logic               i_rd,
    output b64d_pkg::t_job     o_rd_job,
    output logic               o_full,
    output logic               o_has_data
);

    b64d_pkg::t_job                r_mem [b64d_pkg::QDEPTH];
    logic [b64d_pkg::QAW-1:0]      r_wr_ptr;
    logic [b64d_pkg::QAW-1:0]      r_rd_ptr;
    logic [b64d_pkg::QCW-1:0]      r_count;

    assign o_full     = (r_count == b64d_pkg::QCW'(b64d_pkg::QDEPTH));
    assign o_has_data = (r_count != '0);
    assign o_rd_job   = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

`ifndef SYNTH
    // No write lands on a full queue and no read comes from an empty one.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> o_has_data)
        else $error("job queue underflow");
`endif

endmodule

[hw/rtl/b64d_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// b64d_back
// Takes jobs from the queue and hands out their results one per request.
// ============================================================================

module b64d_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_has_job,
    input  b64d_pkg::t_job     i_job,
    output logic               o_take,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [7:0]         o_data_byte,
    output logic               o_byte_valid,
    output logic               o_string_end,
    output logic               o_run_last
);

    b64d_pkg::t_job r_job;
    logic [1:0]     r_idx;
    logic           r_busy;
    logic           w_last;
    logic           w_done;

    assign w_last  = (r_idx == r_job.num - 2'd1);
    assign w_done  = !r_busy || (i_pop && w_last);
    assign o_take  = w_done && i_has_job;
    assign o_empty = !r_busy;

    // Result fields from the current job.
    always_comb begin
        case (r_idx)
            2'd0:    o_data_byte = r_job.b0;
            2'd1:    o_data_byte = r_job.b1;
            default: o_data_byte = r_job.b2;
        endcase
    end
    assign o_byte_valid = r_job.vld;
    assign o_run_last   = w_last;
    assign o_string_end = r_job.str_end && w_last;

    // Step through the results and load the next job behind the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_take) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (w_done) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (i_pop) begin
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_job <= i_job;
        end
    end

`ifndef SYNTH
    // The result index never runs past the job's result count.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_job.num))
        else $error("result index beyond job");
`endif

endmodule

[hw/rtl/base64_stream_decoder_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// base64_stream_decoder_core
// Streaming base64 decoder: one character in, decoded bytes out.
// ============================================================================
//
//  Channel  | Direction | Handshake   | Payload
//  ---------+-----------+-------------+-------------------------------------
//  input    | in        | push / full | i_char_code, i_final_char
//  result   | out       | pop / empty | o_data_byte, o_byte_valid,
//           |           |             | o_string_end, o_run_last
//
//  One character is accepted per cycle while full is low; the front part
//  decodes it in the cycle of acceptance. Results leave the back part at
//  one per cycle while pop is high, a full group giving three bytes. A
//  four-entry job queue between them absorbs bursts; full rises only when
//  the result side stalls. Each job is registered in the queue, then in the
//  back part. Reset is synchronous and clears the group, stop flag and queue.

module base64_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_code,
    input  logic        i_final_char,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_data_byte,
    output logic        o_byte_valid,
    output logic        o_string_end,
    output logic        o_run_last
);

    logic           w_accept;
    logic           w_job_valid;
    b64d_pkg::t_job w_job;
    b64d_pkg::t_job w_head;
    logic           w_take;
    logic           w_has_job;

    assign w_accept = push && !full;

    // Front part: decode and form jobs.
    b64d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_char_code  (i_char_code),
        .i_final_char (i_final_char),
        .o_job_valid  (w_job_valid),
        .o_job        (w_job)
    );

    // Job queue between the two parts.
    b64d_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_job_valid),
        .i_wr_job   (w_job),
        .i_rd       (w_take),
        .o_rd_job   (w_head),
        .o_full     (full),
        .o_has_data (w_has_job)
    );

    // Back part: hand out results.
    b64d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_has_job    (w_has_job),
        .i_job        (w_head),
        .o_take       (w_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_data_byte  (o_data_byte),
        .o_byte_valid (o_byte_valid),
        .o_string_end (o_string_end),
        .o_run_last   (o_run_last)
    );

endmodule

[dv/tb_base64_stream_decoder_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_base64_stream_decoder_core
// Self-checking testbench for the streaming base64 decoder. Character
// requests are driven through the push/full side and decoded bytes are
// drained through the pop/empty side. Both sides insert random idle cycles.
// A scoreboard decodes every accepted character on its own and compares
// each popped result with the oldest expected result, field by field.
// ============================================================================

module tb_base64_stream_decoder_core;

    localparam int LIMIT        = 300000;
    localparam int RANDOM_ITEMS = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam string ALPHABET  =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // One decoded result as it should leave the block.
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       str_end;
        logic       last;
    } t_dec_res;

    // Scoreboard: decodes the character stream and holds the pending bytes.
    class b64_scoreboard;
        logic [5:0] held [3];
        logic [1:0] count;
        bit         halted;
        t_dec_res   pending_bytes [$];
        int         errors;

        function new();
            clear_group();
            halted = 0;
            errors = 0;
        endfunction

        function void clear_group();
            held  = '{default: '0};
            count = '0;
        endfunction

        // Returns the 6-bit value of a character; bit 6 marks a stop character.
        function logic [6:0] char_value(logic [7:0] c);
            if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
            if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 26)};
            if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 52)};
            if (c == b64d_pkg::CH_PLUS)  return 7'd62;
            if (c == b64d_pkg::CH_SLASH) return 7'd63;
            return 7'h40;
        endfunction

        function t_dec_res byte_res(logic [7:0] d);
            t_dec_res r;
            r = '{data: d, valid: 1'b1, str_end: 1'b0, last: 1'b0};
            return r;
        endfunction

        // Notes one accepted character request and queues the bytes it yields.
        function void note_char(logic [7:0] c, logic f);
            t_dec_res   r [$];
            t_dec_res   marker;
            logic [6:0] v;
            logic [5:0] s2;
            if (!halted) begin
                v = char_value(c);
                if (v[6]) begin
                    halted = 1;
                end else if (count == 2'd3) begin
                    r.insert(r.size(), byte_res({held[0], held[1][5:4]}));
                    r.insert(r.size(), byte_res({held[1][3:0], held[2][5:2]}));
                    r.insert(r.size(), byte_res({held[2][1:0], v[5:0]}));
                    clear_group();
                end else begin
                    held[count] = v[5:0];
                    count       = count + 2'd1;
                end
            end
            // The final character flushes the open group and closes the string.
            if (f) begin
                s2 = (count == 2'd3) ? held[2] : 6'd0;
                if (count >= 2'd2) r.insert(r.size(), byte_res({held[0], held[1][5:4]}));
                if (count == 2'd3) r.insert(r.size(), byte_res({held[1][3:0], s2[5:2]}));
                if (r.size() == 0) begin
                    marker = '{data: 8'd0, valid: 1'b0, str_end: 1'b0, last: 1'b0};
                    r.insert(r.size(), marker);
                end
                r[r.size() - 1].str_end = 1'b1;
                clear_group();
                halted = 0;
            end
            if (r.size() > 0) r[r.size() - 1].last = 1'b1;
            foreach (r[i]) pending_bytes.insert(pending_bytes.size(), r[i]);
        endfunction

        function void cmp_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
            if (exp_val !== act_val) begin
                $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
                errors++;
            end
        endfunction

        // Checks one popped result against the oldest pending byte.
        function void check_result(logic [7:0] d, logic v, logic e, logic l);
            t_dec_res x;
            if (pending_bytes.size() == 0) begin
                $error("result with nothing pending: data_byte %0h", d);
                errors++;
                return;
            end
            x = pending_bytes.pop_front();
            cmp_field("data_byte", x.data, d);
            cmp_field("byte_valid", 8'(x.valid), 8'(v));
            cmp_field("string_end", 8'(x.str_end), 8'(e));
            cmp_field("run_last", 8'(x.last), 8'(l));
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_char_code;
    logic       i_final_char;
    logic       empty;
    logic       pop;
    logic [7:0] o_data_byte;
    logic       o_byte_valid;
    logic       o_string_end;
    logic       o_run_last;

    b64_scoreboard sb;
    int            accepted    = 0;
    int            popped      = 0;
    int            cycle_count = 0;
    bit            no_idle     = 0;

    base64_stream_decoder_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_char_code  (i_char_code),
        .i_final_char (i_final_char),
        .empty        (empty),
        .pop          (pop),
        .o_data_byte  (o_data_byte),
        .o_byte_valid (o_byte_valid),
        .o_string_end (o_string_end),
        .o_run_last   (o_run_last)
    );

    always #5 i_clk = ~i_clk;

    // Watch both handshakes at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                sb.note_char(i_char_code, i_final_char);
                accepted++;
            end
            if (pop && !empty) begin
                sb.check_result(o_data_byte, o_byte_valid, o_string_end, o_run_last);
                popped++;
            end
        end
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("** base64_stream_decoder_core: FAILED **");
            $finish;
        end
    end

    function automatic int next_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    // Drives one character request; called and returns at a falling edge.
    task automatic send_char(input logic [7:0] c, input logic f);
        int gap;
        int target;
        gap = next_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push         <= 1'b1;
        i_char_code  <= c;
        i_final_char <= f;
        target = accepted + 1;
        do @(negedge i_clk); while (accepted < target);
    endtask

    // Sends a whole string with the final flag on its last character.
    task automatic send_seq(input logic [7:0] chars [$]);
        foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
    endtask

    task automatic send_text(input string s);
        logic [7:0] chars [$];
        for (int i = 0; i < s.len(); i++) chars.insert(chars.size(), s[i]);
        send_seq(chars);
    endtask

    // Result side: random pop stalls between accepted results.
    initial begin
        int gap;
        int target;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = next_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            target = popped + 1;
            do @(negedge i_clk); while (popped < target);
        end
    end

    initial begin
        logic [7:0] chars [$];
        int         sent;
        int         kind;
        int         len;
        int         pos;
        int         drain;
        sb           = new();
        i_rst_n      = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        i_char_code  = '0;
        i_final_char = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full group on the final character, one and two byte
        // flushes, a lone sextet, a stop character as final, padding, and
        // alphabet edges mixed with the lowest and highest codes.
        send_text("TWFu");
        send_text("TQ");
        send_text("TWE");
        send_text("A");
        send_text("=");
        send_text("QQ==");
        chars = '{"/", "+", "0", "9", 8'h00, "a", "b", 8'hFF};
        send_seq(chars);

        // Random strings: mostly well formed, some padded, some noisy.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 7) == 0);
            kind    = $urandom_range(0, 9);
            len     = $urandom_range(1, 12);
            chars.delete();
            if (kind >= 6 && kind <= 7) begin
                // Padded groups ending in one or two pad characters.
                len = 4 * $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    chars.insert(chars.size(), ALPHABET[$urandom_range(0, 63)]);
                chars[len - 1] = b64d_pkg::CH_PAD;
                if ($urandom_range(0, 1)) chars[len - 2] = b64d_pkg::CH_PAD;
            end else if (kind == 8) begin
                for (int i = 0; i < len; i++)
                    chars.insert(chars.size(), 8'($urandom_range(0, 255)));
            end else begin
                for (int i = 0; i < len; i++)
                    chars.insert(chars.size(), ALPHABET[$urandom_range(0, 63)]);
                if (kind == 9) begin
                    pos = $urandom_range(0, len - 1);
                    chars[pos] = $urandom_range(0, 1) ? b64d_pkg::CH_PAD
                                                      : 8'($urandom_range(0, 255));
                end
            end
            send_seq(chars);
            sent += chars.size();
        end
        push    <= 1'b0;
        no_idle = 0;

        // Wait for every pending byte, then watch for stray results.
        while (sb.pending_bytes.size() > 0) @(negedge i_clk);
        drain = DRAIN_CYCLES;
        repeat (drain) @(negedge i_clk);

        if (sb.errors == 0) begin
            $display("** base64_stream_decoder_core: PASSED **");
        end else begin
            $display("** base64_stream_decoder_core: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_queue.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_stream_decoder_core.sv
dv/tb_base64_stream_decoder_core.sv
